FILE: src/lkvc_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkvc_pkg;

  // Default number of entries
  localparam int CAPACITY_DEF = 4;

  // Operation codes carried on the cmd field
  localparam logic CMD_GET = 1'b0;
  localparam logic CMD_PUT = 1'b1;

  // Value returned by a get that misses
  localparam logic signed [31:0] MISS_VALUE = -32'sd1;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_UPDATE
  } lkvc_state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic capture;  // latch the incoming item
    logic lookup;   // register compare results, issue data read
    logic commit;   // update entries and load the result register
  } lkvc_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic out_busy; // result register holds an item that is being stalled
  } lkvc_status_t;

endpackage
`default_nettype wire

FILE: src/lru_key_value_cache_top.sv
// Top level of the LRU key-value cache.
// out_valid rises when an accepted item has passed the lookup and then the update step.
// The controller handles one item at a time: a new item is accepted only once the last has committed.
// A stalled result holds the update step until the result register frees.
// Reset (synchronous, active low) clears all valid bits, ranks, out_valid and the FSM;
// keys and values are left as they are and are read only once written.
`default_nettype none
module lru_key_value_cache_top
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_cmd,
  input  wire logic [31:0]        in_key,
  input  wire logic signed [31:0] in_value,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic signed [31:0]      out_read_value,
  output logic                    out_evicted
);

  lkvc_cmd_t    cmd;
  lkvc_status_t status;

  lkvc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  lkvc_datapath #(
    .CAPACITY (CAPACITY)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_cmd         (in_cmd),
    .in_key         (in_key),
    .in_value       (in_value),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_hit        (out_hit),
    .out_read_value (out_read_value),
    .out_evicted    (out_evicted)
  );

endmodule
`default_nettype wire

FILE: src/lkvc_ctrl.sv
// Controller state machine for the LRU key-value cache.
`default_nettype none
module lkvc_ctrl
  import lkvc_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire lkvc_status_t status,
  output lkvc_cmd_t         cmd
);

  lkvc_state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and command decode
  always_comb begin
    state_nxt   = state_r;
    cmd         = '0;
    in_stall    = 1'b1;
    unique case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        cmd.lookup = 1'b1;
        state_nxt  = ST_UPDATE;
      end
      ST_UPDATE: begin
        // wait here until the result register can take the item
        if (!status.out_busy) begin
          cmd.commit = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule
`default_nettype wire

FILE: src/lkvc_datapath.sv
// Entry storage, key compare, recency ranks and result register.
`default_nettype none
module lkvc_datapath
  import lkvc_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_cmd,
  input  wire logic [31:0]        in_key,
  input  wire logic signed [31:0] in_value,
  input  wire lkvc_cmd_t          cmd,
  output lkvc_status_t            status,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_hit,
  output logic signed [31:0]      out_read_value,
  output logic                    out_evicted
);

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam logic [IW-1:0] RANK_OLDEST = IW'(CAPACITY - 1);

  // Captured item
  logic               cmd_r;
  logic [31:0]        key_r;
  logic signed [31:0] value_r;

  // Per-entry state
  logic [CAPACITY-1:0] valid_r;
  logic [31:0]         ekey_r  [CAPACITY];
  logic [IW-1:0]       rank_r  [CAPACITY];
  logic signed [31:0]  data_mem [CAPACITY];
  logic signed [31:0]  rd_data_r;

  // Lookup results
  logic          hit_r, full_r;
  logic [IW-1:0] tgt_r;
  logic [IW-1:0] tgt_rank_r;

  // Result register
  logic               out_valid_r;
  logic               out_hit_r;
  logic signed [31:0] out_value_r;
  logic               out_evicted_r;

  logic [CAPACITY-1:0] match;
  logic                hit_c, full_c;
  logic [IW-1:0]       hit_idx, free_idx, victim_idx, tgt_c;

  // Parallel key compare and victim / free slot search
  always_comb begin
    hit_c      = 1'b0;
    hit_idx    = '0;
    free_idx   = '0;
    victim_idx = '0;
    full_c     = &valid_r;
    for (int i = 0; i < CAPACITY; i++) begin
      match[i] = valid_r[i] && (ekey_r[i] == key_r);
    end
    // lowest index wins each search
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (match[i]) begin
        hit_c   = 1'b1;
        hit_idx = IW'(i);
      end
      if (!valid_r[i]) begin
        free_idx = IW'(i);
      end
      if (rank_r[i] == RANK_OLDEST) begin
        victim_idx = IW'(i);
      end
    end
    if (hit_c) begin
      tgt_c = hit_idx;
    end else if (full_c) begin
      tgt_c = victim_idx;
    end else begin
      tgt_c = free_idx;
    end
  end

  // Item capture and lookup registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r   <= in_cmd;
      key_r   <= in_key;
      value_r <= in_value;
    end
    if (cmd.lookup) begin
      hit_r      <= hit_c;
      full_r     <= full_c;
      tgt_r      <= tgt_c;
      tgt_rank_r <= rank_r[tgt_c];
    end
  end

  // Value memory: read at the hit entry, written on a put
  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      rd_data_r <= data_mem[hit_idx];
    end
    if (cmd.commit && cmd_r == CMD_PUT) begin
      data_mem[tgt_r] <= value_r;
    end
  end

  logic touch, fill;
  assign touch = hit_r || (cmd_r == CMD_PUT);
  assign fill  = (cmd_r == CMD_PUT) && !hit_r && !full_r;

  // Valid bits and recency ranks
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      for (int i = 0; i < CAPACITY; i++) begin
        rank_r[i] <= '0;
      end
    end else if (cmd.commit && touch) begin
      for (int i = 0; i < CAPACITY; i++) begin
        if (tgt_r == IW'(i)) begin
          rank_r[i] <= '0;
          valid_r[i] <= 1'b1;
        end else if (valid_r[i] && (fill || rank_r[i] < tgt_rank_r)) begin
          rank_r[i] <= rank_r[i] + 1'b1;
        end
      end
    end
  end

  // Keys, written on a put that misses
  always_ff @(posedge clk) begin
    for (int i = 0; i < CAPACITY; i++) begin
      if (cmd.commit && cmd_r == CMD_PUT && !hit_r && tgt_r == IW'(i)) begin
        ekey_r[i] <= key_r;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.commit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_hit_r     <= hit_r;
      out_evicted_r <= (cmd_r == CMD_PUT) && !hit_r && full_r;
      if (cmd_r == CMD_PUT) begin
        out_value_r <= '0;
      end else if (hit_r) begin
        out_value_r <= rd_data_r;
      end else begin
        out_value_r <= MISS_VALUE;
      end
    end
  end

  assign status.out_busy = out_valid_r && out_stall;
  assign out_valid       = out_valid_r;
  assign out_hit         = out_hit_r;
  assign out_read_value  = out_value_r;
  assign out_evicted     = out_evicted_r;

endmodule
`default_nettype wire

FILE: src/lkvc_checker.sv
// Port-level assertions for the LRU key-value cache, bound to the top level.
`default_nettype none
module lkvc_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_hit,
  input wire logic [31:0] out_read_value,
  input wire logic        out_evicted
);

  // An accepted item keeps the input closed while it is worked on
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input open right after an item was accepted");

  // A stalled result holds
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_read_value)
                                  && $stable(out_hit) && $stable(out_evicted)))
    else $error("stalled result changed");

  // An eviction is a put that missed
  a_evict_is_put_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_evicted) |-> (!out_hit && out_read_value == 32'd0))
    else $error("eviction reported with a hit or nonzero value");

  // A new result only appears while an item is in progress
  a_result_from_item: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared with no item in progress");

endmodule

bind lru_key_value_cache_top lkvc_checker u_lkvc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_hit        (out_hit),
  .out_read_value (out_read_value),
  .out_evicted    (out_evicted)
);
`default_nettype wire
